[sv/brr_pkg.sv]
// ---------------------------------------------------------------------------
// brr_pkg: shared types and arithmetic for the block ADPCM decoder
// Holds the header field layout, the queued data item and the nibble decode.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package brr_pkg;

    // header byte layout
    localparam int unsigned SHIFT_MSB  = 7;
    localparam int unsigned SHIFT_LSB  = 4;
    localparam int unsigned FILT_MSB   = 3;
    localparam int unsigned FILT_LSB   = 2;
    localparam int unsigned LOOP_BIT   = 1;
    localparam int unsigned END_BIT    = 0;

    // data bytes that follow each header
    localparam logic [3:0] DATA_BYTES  = 4'd8;
    localparam logic [3:0] PHASE_HDR   = 4'd0;

    // filter codes
    localparam logic [1:0] FILT_NONE   = 2'd0;
    localparam logic [1:0] FILT_ONE    = 2'd1;
    localparam logic [1:0] FILT_TWO    = 2'd2;
    localparam logic [1:0] FILT_THREE  = 2'd3;

    localparam logic [15:0] SIGN_FLIP  = 16'h8000;

    // one data byte with the header fields it is decoded under
    typedef struct packed {
        logic [7:0] coded_byte;
        logic [3:0] range_shift;
        logic [1:0] filter_select;
        logic       last_of_end;
        logic       loop_flag;
    } t_brr_item;

    // signed quotient by 2**sh, truncated toward zero
    function automatic logic signed [24:0] quot_pow2(
        input logic signed [24:0] x,
        input logic [2:0]         sh
    );
        logic signed [24:0] bias;
        bias = x[24] ? ((25'sd1 <<< sh) - 25'sd1) : 25'sd0;
        return (x + bias) >>> sh;
    endfunction

    // prediction from the last two samples
    function automatic logic [15:0] predict(
        input logic [1:0]  filt,
        input logic [15:0] p1,
        input logic [15:0] p2
    );
        logic signed [24:0] s1;
        logic signed [24:0] s2;
        logic signed [24:0] pred;
        s1 = {{9{p1[15]}}, p1};
        s2 = {{9{p2[15]}}, p2};
        case (filt)
            FILT_ONE:   pred = quot_pow2(s1 * 25'sd15, 3'd4);
            FILT_TWO:   pred = quot_pow2(s1 * 25'sd61, 3'd5)
                               - quot_pow2(s2 * 25'sd15, 3'd4);
            FILT_THREE: pred = quot_pow2(s1 * 25'sd115, 3'd6)
                               - quot_pow2(s2 * 25'sd13, 3'd4);
            default:    pred = 25'sd0;
        endcase
        return pred[15:0];
    endfunction

    // one nibble: sign extend, shift, add prediction, wrap to 16 bits
    function automatic logic [15:0] decode_nibble(
        input logic [3:0]  nib,
        input logic [3:0]  shift,
        input logic [1:0]  filt,
        input logic [15:0] p1,
        input logic [15:0] p2
    );
        logic [15:0] ext;
        ext = {{12{nib[3]}}, nib};
        ext = ext << shift;
        return ext + predict(filt, p1, p2);
    endfunction

endpackage

[sv/brr_byte_if.sv]
// ---------------------------------------------------------------------------
// brr_byte_if: compressed byte channel
// Valid/ready channel carrying one coded byte per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface brr_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] coded_byte;

    modport source (output valid, output coded_byte, input ready);
    modport sink   (input valid, input coded_byte, output ready);
endinterface

[sv/brr_pair_if.sv]
// ---------------------------------------------------------------------------
// brr_pair_if: decoded sample pair channel
// Valid/ready channel carrying two samples and block flags per beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

interface brr_pair_if;
    logic        valid;
    logic        ready;
    logic [15:0] first_sample;
    logic [15:0] second_sample;
    logic        end_of_sample;
    logic        loop_marked;

    modport source (output valid, output first_sample, output second_sample,
                    output end_of_sample, output loop_marked, input ready);
    modport sink   (input valid, input first_sample, input second_sample,
                    input end_of_sample, input loop_marked, output ready);
endinterface

[sv/brr_front.sv]
// ---------------------------------------------------------------------------
// brr_front: byte classifier
// Tracks the block phase, latches header fields and forwards data bytes.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module brr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    brr_byte_if.sink           i_byte,
    input  logic               i_q_full,
    output logic               o_push,
    output brr_pkg::t_brr_item o_item
);

    logic [3:0] r_phase;
    logic [3:0] r_shift;
    logic [1:0] r_filt;
    logic       r_end;
    logic       r_loop;

    logic       w_accept;
    logic       w_is_hdr;

    // a header is expected at phase zero and at any phase out of range
    assign w_is_hdr     = (r_phase == brr_pkg::PHASE_HDR) || (r_phase > brr_pkg::DATA_BYTES);
    assign i_byte.ready = !i_q_full;
    assign w_accept     = i_byte.valid && i_byte.ready;
    assign o_push       = w_accept && !w_is_hdr;

    // data beat plus the header fields in force
    always_comb begin
        o_item.coded_byte    = i_byte.coded_byte;
        o_item.range_shift   = r_shift;
        o_item.filter_select = r_filt;
        o_item.last_of_end   = (r_phase == 4'd1) && r_end;
        o_item.loop_flag     = r_loop;
    end

    // phase and header state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= brr_pkg::PHASE_HDR;
            r_shift <= '0;
            r_filt  <= '0;
            r_end   <= 1'b0;
            r_loop  <= 1'b0;
        end else if (w_accept) begin
            if (w_is_hdr) begin
                r_phase <= brr_pkg::DATA_BYTES;
                r_shift <= i_byte.coded_byte[brr_pkg::SHIFT_MSB:brr_pkg::SHIFT_LSB];
                r_filt  <= i_byte.coded_byte[brr_pkg::FILT_MSB:brr_pkg::FILT_LSB];
                r_loop  <= i_byte.coded_byte[brr_pkg::LOOP_BIT];
                r_end   <= i_byte.coded_byte[brr_pkg::END_BIT];
            end else begin
                r_phase <= r_phase - 4'd1;
            end
        end
    end

endmodule

[sv/brr_queue.sv]
// ---------------------------------------------------------------------------
// brr_queue: small item queue
// First-in first-out buffer between the classifier and the decode stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module brr_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  brr_pkg::t_brr_item i_item,
    input  logic               i_pop,
    output logic               o_full,
    output logic               o_valid,
    output brr_pkg::t_brr_item o_item
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

    brr_pkg::t_brr_item r_mem [DEPTH];
    logic [PW-1:0]      r_wr;
    logic [PW-1:0]      r_rd;
    logic [CW-1:0]      r_cnt;

    logic               w_push;
    logic               w_pop;

    assign o_full  = (r_cnt == FULL_CNT);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    // storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == LAST_SLOT) ? '0 : r_wr + PW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == LAST_SLOT) ? '0 : r_rd + PW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

[sv/brr_back.sv]
// ---------------------------------------------------------------------------
// brr_back: sample decode stage
// Decodes both nibbles of a data byte against the history and registers
// the sample pair for the output channel.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module brr_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_q_valid,
    input  brr_pkg::t_brr_item i_item,
    output logic               o_pop,
    brr_pair_if.source         o_pair
);

    logic [15:0] r_p1;
    logic [15:0] r_p2;
    logic        r_valid;
    logic [15:0] r_first;
    logic [15:0] r_second;
    logic        r_end;
    logic        r_loop;

    logic [15:0] w_s0;
    logic [15:0] w_s1;

    // take a queued beat when the output register is free or draining
    assign o_pop = i_q_valid && (!r_valid || o_pair.ready);

    // two chained predictor steps, high nibble first
    always_comb begin
        w_s0 = brr_pkg::decode_nibble(i_item.coded_byte[7:4], i_item.range_shift,
                                      i_item.filter_select, r_p1, r_p2);
        w_s1 = brr_pkg::decode_nibble(i_item.coded_byte[3:0], i_item.range_shift,
                                      i_item.filter_select, w_s0, r_p1);
    end

    // history and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p1    <= '0;
            r_p2    <= '0;
            r_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                if (i_item.last_of_end) begin
                    r_p1 <= '0;
                    r_p2 <= '0;
                end else begin
                    r_p1 <= w_s1;
                    r_p2 <= w_s0;
                end
            end else if (o_pair.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_first  <= w_s0 ^ brr_pkg::SIGN_FLIP;
            r_second <= w_s1 ^ brr_pkg::SIGN_FLIP;
            r_end    <= i_item.last_of_end;
            r_loop   <= i_item.loop_flag;
        end
    end

    assign o_pair.valid         = r_valid;
    assign o_pair.first_sample  = r_first;
    assign o_pair.second_sample = r_second;
    assign o_pair.end_of_sample = r_end;
    assign o_pair.loop_marked   = r_loop;

endmodule

[sv/brr_adpcm_block_decoder.sv]
// ---------------------------------------------------------------------------
// brr_adpcm_block_decoder: block ADPCM sample decoder
// Turns a stream of 9-byte compressed blocks into 16-bit sample pairs.
// ---------------------------------------------------------------------------
// usage:
//   i_byte carries one compressed byte per beat. The first byte of each
//   block is a header (range shift, filter, loop and end flags) and gives
//   no result; each of the eight data bytes after it gives one beat on
//   o_pair with two offset-binary samples, the high nibble first.
//   end_of_sample marks the last pair of a block flagged end; the sample
//   history then clears before the next block.
// timing:
//   one byte is taken per cycle while the queue is not full; a data byte
//   accepted is written into the queue, and the decode stage takes it from
//   there into the output register that drives o_pair. Rate is set by the
//   decode stage, which runs both predictor steps of a byte combinationally.
// reset and stall:
//   reset clears the block phase (a header is expected), the header fields,
//   the history and the queue. When o_pair is held off, the output register
//   keeps its pair, the queue fills with up to QUEUE_DEPTH data bytes, and
//   then i_byte.ready drops until the receiver takes a beat.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module brr_adpcm_block_decoder #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    brr_byte_if.sink    i_byte,
    brr_pair_if.source  o_pair
);

    logic               w_push;
    logic               w_pop;
    logic               w_full;
    logic               w_q_valid;
    brr_pkg::t_brr_item w_in_item;
    brr_pkg::t_brr_item w_out_item;

    // classify bytes and track block phase
    brr_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_byte   (i_byte),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_item   (w_in_item)
    );

    // decouple classifier from decode
    brr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_valid (w_q_valid),
        .o_item  (w_out_item)
    );

    // decode sample pairs
    brr_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_q_valid),
        .i_item    (w_out_item),
        .o_pop     (w_pop),
        .o_pair    (o_pair)
    );

endmodule
